### design/dar_pkg.sv
package dar_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned DivSteps = 2 * WordW;

	// item kinds
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_MERGE = 2'd1;
	localparam logic [1:0] KIND_FIN   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_OVF   = 2'd2;

	typedef struct packed {
		logic [1:0]              kind;
		logic signed [WordW-1:0] value_high;
		logic [WordW-1:0]        value_low;
		logic [WordW-1:0]        partial_count;
	} in_t;

	typedef struct packed {
		logic signed [WordW-1:0] avg_high;
		logic [WordW-1:0]        avg_low;
		logic [1:0]              status;
	} out_t;

	typedef struct packed {
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
		logic             cin;
	} alu_in_t;

	typedef struct packed {
		logic [WordW-1:0] s;
		logic             cout;
	} alu_out_t;

endpackage

### design/dar_alu.sv
module dar_alu (
	input  dar_pkg::alu_in_t  op,
	output dar_pkg::alu_out_t res
);

	logic [dar_pkg::WordW:0] full;

	always_comb begin
		full = {1'b0, op.a} + {1'b0, op.b} + {{dar_pkg::WordW{1'b0}}, op.cin};
		res.s = full[dar_pkg::WordW-1:0];
		res.cout = full[dar_pkg::WordW];
	end

endmodule

### design/decimal_average_round_half_even.sv
// channel  | ports                 | handshake
// ---------+-----------------------+-------------------------------------------
// command  | cmd (dar_pkg::in_t)   | taken at the edge where start=1, busy=0
// result   | result (dar_pkg::out_t)| valid high for one cycle, no hold-off
//
// one 64-bit adder does all the arithmetic under the sequencer below
// add / merge: low half, high half, count, then back to idle for the next accept
// finalize: status result straight from idle when overflowed or empty, else the
//   128 restoring divide steps through the adder plus negate and round passes
// kind 3 words are dropped in their accept cycle
// arst_n clears sum, count and overflow flag; the result side never stalls
module decimal_average_round_half_even (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dar_pkg::in_t  cmd,
	output logic          valid,
	output dar_pkg::out_t result
);

	localparam int unsigned W = dar_pkg::WordW;
	localparam int unsigned StepW = $clog2(dar_pkg::DivSteps);
	localparam logic [StepW-1:0] LastStep = StepW'(dar_pkg::DivSteps - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_ADD_LO, S_ADD_HI, S_CNT, S_NEG_LO, S_NEG_HI, S_DIV,
		S_RND_DIST, S_RND_CMP, S_INC_LO, S_INC_HI, S_OUT_LO, S_OUT_HI
	} state_t;

	state_t            state_q;
	logic [W-1:0]      sum_hi_q, sum_lo_q, cnt_q;
	logic              ovf_q;
	logic [1:0]        kind_q;
	logic [W-1:0]      vh_q, vl_q, pc_q;
	logic [2*W-1:0]    num_q;
	logic [W-1:0]      rem_q, tmp_q;
	logic              carry_q, neg_q;
	logic [StepW-1:0]  step_q;
	logic              valid_q;
	dar_pkg::out_t     res_q;

	dar_pkg::alu_in_t  alu_op;
	dar_pkg::alu_out_t alu_res;

	logic [W-1:0] shifted;
	logic         div_ok;
	logic         sum_ovf;

	dar_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	assign shifted = {rem_q[W-2:0], num_q[2*W-1]};
	assign div_ok  = rem_q[W-1] | alu_res.cout;
	// same operand signs, different result sign
	assign sum_ovf = (sum_hi_q[W-1] == vh_q[W-1]) && (alu_res.s[W-1] != sum_hi_q[W-1]);

	always_comb begin
		alu_op.a = '0;
		alu_op.b = '0;
		alu_op.cin = 1'b0;
		case (state_q)
			S_ADD_LO: begin
				alu_op.a = sum_lo_q;
				alu_op.b = vl_q;
			end
			S_ADD_HI: begin
				alu_op.a = sum_hi_q;
				alu_op.b = vh_q;
				alu_op.cin = carry_q;
			end
			S_CNT: begin
				alu_op.a = cnt_q;
				alu_op.b = (kind_q == dar_pkg::KIND_ADD) ? W'(1) : pc_q;
			end
			S_NEG_LO, S_OUT_LO: begin
				alu_op.a = ~num_q[W-1:0];
				alu_op.cin = 1'b1;
			end
			S_NEG_HI, S_OUT_HI: begin
				alu_op.a = ~num_q[2*W-1:W];
				alu_op.cin = carry_q;
			end
			S_DIV: begin
				alu_op.a = shifted;
				alu_op.b = ~cnt_q;
				alu_op.cin = 1'b1;
			end
			S_RND_DIST: begin
				alu_op.a = cnt_q;
				alu_op.b = ~rem_q;
				alu_op.cin = 1'b1;
			end
			S_RND_CMP: begin
				alu_op.a = tmp_q;
				alu_op.b = ~rem_q;
				alu_op.cin = 1'b1;
			end
			S_INC_LO: begin
				alu_op.a = num_q[W-1:0];
				alu_op.cin = carry_q;
			end
			S_INC_HI: begin
				alu_op.a = num_q[2*W-1:W];
				alu_op.cin = carry_q;
			end
			default: begin
				alu_op.a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sum_hi_q <= '0;
			sum_lo_q <= '0;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						kind_q <= cmd.kind;
						vh_q   <= $unsigned(cmd.value_high);
						vl_q   <= cmd.value_low;
						pc_q   <= cmd.partial_count;
						case (cmd.kind)
							dar_pkg::KIND_ADD, dar_pkg::KIND_MERGE: begin
								state_q <= S_ADD_LO;
							end
							dar_pkg::KIND_FIN: begin
								if (ovf_q || cnt_q == '0) begin
									res_q.avg_high <= '0;
									res_q.avg_low  <= '0;
									res_q.status   <= ovf_q ? dar_pkg::ST_OVF : dar_pkg::ST_EMPTY;
									valid_q  <= 1'b1;
									sum_hi_q <= '0;
									sum_lo_q <= '0;
									cnt_q    <= '0;
									ovf_q    <= 1'b0;
								end else begin
									num_q   <= {sum_hi_q, sum_lo_q};
									neg_q   <= sum_hi_q[W-1];
									rem_q   <= '0;
									step_q  <= '0;
									state_q <= sum_hi_q[W-1] ? S_NEG_LO : S_DIV;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ADD_LO: begin
					tmp_q   <= alu_res.s;
					carry_q <= alu_res.cout;
					state_q <= S_ADD_HI;
				end
				S_ADD_HI: begin
					if (sum_ovf) begin
						ovf_q <= 1'b1;
					end else begin
						sum_hi_q <= alu_res.s;
						sum_lo_q <= tmp_q;
					end
					state_q <= S_CNT;
				end
				S_CNT: begin
					cnt_q   <= alu_res.s;
					state_q <= S_IDLE;
				end
				S_NEG_LO: begin
					num_q[W-1:0] <= alu_res.s;
					carry_q      <= alu_res.cout;
					state_q      <= S_NEG_HI;
				end
				S_NEG_HI: begin
					num_q[2*W-1:W] <= alu_res.s;
					state_q        <= S_DIV;
				end
				S_DIV: begin
					// restoring step, quotient bits shift in behind the dividend
					rem_q  <= div_ok ? alu_res.s : shifted;
					num_q  <= {num_q[2*W-2:0], div_ok};
					step_q <= step_q + StepW'(1);
					if (step_q == LastStep) begin
						state_q <= S_RND_DIST;
					end
				end
				S_RND_DIST: begin
					tmp_q   <= alu_res.s;
					state_q <= S_RND_CMP;
				end
				S_RND_CMP: begin
					// round up when past half, or at half with an odd quotient
					carry_q <= ~alu_res.cout | ((alu_res.s == '0) & num_q[0]);
					state_q <= S_INC_LO;
				end
				S_INC_LO: begin
					num_q[W-1:0] <= alu_res.s;
					carry_q      <= alu_res.cout;
					state_q      <= S_INC_HI;
				end
				S_INC_HI: begin
					num_q[2*W-1:W] <= alu_res.s;
					if (neg_q) begin
						state_q <= S_OUT_LO;
					end else begin
						res_q.avg_high <= $signed(alu_res.s);
						res_q.avg_low  <= num_q[W-1:0];
						res_q.status   <= dar_pkg::ST_OK;
						valid_q  <= 1'b1;
						sum_hi_q <= '0;
						sum_lo_q <= '0;
						cnt_q    <= '0;
						ovf_q    <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				S_OUT_LO: begin
					num_q[W-1:0] <= alu_res.s;
					carry_q      <= alu_res.cout;
					state_q      <= S_OUT_HI;
				end
				S_OUT_HI: begin
					res_q.avg_high <= $signed(alu_res.s);
					res_q.avg_low  <= num_q[W-1:0];
					res_q.status   <= dar_pkg::ST_OK;
					valid_q  <= 1'b1;
					sum_hi_q <= '0;
					sum_lo_q <= '0;
					cnt_q    <= '0;
					ovf_q    <= 1'b0;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;
	assign result = res_q;

endmodule
